@@ hdl/spq_pkg.sv @@
package spq_pkg;

    // Queue geometry.
    localparam int DEPTH       = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int PRIO_WIDTH  = 8;
    localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

    // Request codes.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Status codes.
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    // One stored entry.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] data_value;
        logic        [PRIO_WIDTH-1:0] priority_level;
    } spq_entry_t;

    // Request word.
    typedef struct packed {
        logic                         req_type;
        logic signed [DATA_WIDTH-1:0] data_value;
        logic        [PRIO_WIDTH-1:0] priority_level;
    } spq_req_t;

    // Response word.
    typedef struct packed {
        logic        [1:0]             status;
        logic signed [DATA_WIDTH-1:0]  removed_data;
        logic        [PRIO_WIDTH-1:0]  removed_priority;
        logic        [COUNT_WIDTH-1:0] fill_count;
    } spq_rsp_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } spq_cmd_t;

endpackage

@@ hdl/spq_cell.sv @@
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  spq_cmd_t   cmd,
    input  logic       occupied,
    input  logic       left_lower,
    input  spq_entry_t new_entry,
    input  spq_entry_t left_entry,
    input  spq_entry_t right_entry,
    output spq_entry_t entry,
    output logic       lower
);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // A free slot, or one holding a strictly lower priority, gives way to the new entry.
    always_comb
    begin
        lower = !occupied || (entry_reg.priority_level < new_entry.priority_level);
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.do_insert && lower)
        begin
            // The first yielding slot takes the new entry; those behind it shift back.
            entry_next = left_lower ? left_entry : new_entry;
        end
        else if (cmd.do_remove)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ hdl/sorted_priority_queue.sv @@
// A response word is loaded into the output register when its request word is accepted.
// One insert or remove per cycle unless stalled; all slots compare and shift in parallel.
// A response word left waiting in the output register stalls the input until it is taken.
// Reset clears the entry count and the output valid flag; the slots are not cleared,
// since only slots below the entry count are ever read.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  spq_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output spq_rsp_t rsp
);

    // Queue state: the number of occupied slots, counted from the front.
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    // Output register.
    logic     rsp_valid_reg;
    logic     rsp_valid_next;
    spq_rsp_t rsp_reg;
    spq_rsp_t rsp_next;

    logic       req_fire;
    logic       queue_full;
    logic       queue_empty;
    spq_cmd_t   cmd;
    spq_entry_t new_entry;

    // Row of cells: each slot's stored entry and whether it yields to the new entry.
    spq_entry_t       slot_entry [DEPTH];
    logic [DEPTH-1:0] slot_lower;
    logic [DEPTH-1:0] slot_occupied;

    // A new request is taken whenever the output register is empty or being emptied.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;

    assign queue_full  = (count_reg == COUNT_WIDTH'(DEPTH));
    assign queue_empty = (count_reg == '0);

    assign new_entry.data_value     = req.data_value;
    assign new_entry.priority_level = req.priority_level;

    always_comb
    begin
        cmd.do_insert = req_fire && (req.req_type == REQ_INSERT) && !queue_full;
        cmd.do_remove = req_fire && (req.req_type == REQ_REMOVE) && !queue_empty;
    end

    // The slots in use always form the front of the row.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_slot
            spq_entry_t left_entry;
            spq_entry_t right_entry;
            logic       left_lower;

            assign slot_occupied[gi] = (count_reg > COUNT_WIDTH'(gi));

            if (gi == 0)
            begin : g_front
                assign left_entry = new_entry;
                assign left_lower = 1'b0;
            end
            else
            begin : g_inner
                assign left_entry = slot_entry[gi-1];
                assign left_lower = slot_lower[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_back
                assign right_entry = slot_entry[gi];
            end
            else
            begin : g_body
                assign right_entry = slot_entry[gi+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (slot_occupied[gi]),
                .left_lower  (left_lower),
                .new_entry   (new_entry),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (slot_entry[gi]),
                .lower       (slot_lower[gi])
            );
        end
    endgenerate

    // Count update and the response word for the request taken this cycle.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_insert)
        begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
        else if (cmd.do_remove)
        begin
            count_next = count_reg - COUNT_WIDTH'(1);
        end

        rsp_next                  = rsp_reg;
        rsp_valid_next            = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (req_fire)
        begin
            rsp_valid_next            = 1'b1;
            rsp_next.status           = STATUS_DONE;
            rsp_next.removed_data     = '0;
            rsp_next.removed_priority = '0;
            rsp_next.fill_count       = count_next;
            if (req.req_type == REQ_INSERT)
            begin
                if (queue_full)
                begin
                    rsp_next.status = STATUS_OVERFLOW;
                end
            end
            else
            begin
                if (queue_empty)
                begin
                    rsp_next.status = STATUS_UNDERFLOW;
                end
                else
                begin
                    // The front slot holds the highest priority, oldest first.
                    rsp_next.removed_data     = slot_entry[0].data_value;
                    rsp_next.removed_priority = slot_entry[0].priority_level;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The count never exceeds the number of slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_WIDTH'(DEPTH))
        else $error("entry count beyond queue depth");

    // A remove from a non-empty queue drops the count by exactly one.
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.req_type == REQ_REMOVE) && !queue_empty)
        |=> (count_reg == $past(count_reg) - COUNT_WIDTH'(1)))
        else $error("remove did not decrement the count");

    // An underflow is only reported for an empty queue, and then nothing is returned.
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == STATUS_UNDERFLOW))
        |-> ((rsp.fill_count == '0) && (rsp.removed_priority == '0)))
        else $error("underflow reported on a non-empty queue");

    // The response word reflects the count the queue now holds.
    a_fill_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $past(req_fire) |-> (rsp.fill_count == count_reg))
        else $error("reported fill count differs from the queue count");

    // Occupied slots stay sorted, highest priority at the front.
    generate
        for (gi = 1; gi < DEPTH; gi++)
        begin : g_order_check
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                slot_occupied[gi]
                |-> (slot_entry[gi-1].priority_level >= slot_entry[gi].priority_level))
                else $error("slot order broken");
        end
    endgenerate

endmodule
